### rtl/minmax_envelope_pyramid_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min/max envelope pyramid
// Short forms for clocked checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MINMAX_ENVELOPE_PYRAMID_MACROS_SVH
`define MINMAX_ENVELOPE_PYRAMID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// Min/max envelope pyramid package
// Field widths, configuration codes and the beat types shared by all modules.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int LEVEL_BITS     = 4;
  localparam int TOTAL_BITS     = 40;
  localparam int WIN_BITS       = 14;
  localparam int LCNT_BITS      = 5;
  localparam int CFG_DATA_BITS  = 14;
  localparam int CFG_ADDR_BITS  = 1;

  localparam int WIN_MIN        = 64;
  localparam int WIN_MAX        = 8192;
  localparam int WIN_RESET      = 256;
  localparam int LCNT_RESET     = 16;
  localparam int DEF_MAX_LEVELS = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LEN  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LEVEL_COUNT = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]         level;
    logic signed [SAMPLE_BITS-1:0] bin_min;
    logic signed [SAMPLE_BITS-1:0] bin_max;
    logic [TOTAL_BITS-1:0]         total_samples;
    logic                          stream_done;
    logic                          last;
  } out_beat_t;

  // One completed base window handed from the front end to the cascade.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic [TOTAL_BITS-1:0]         total;
    logic                          eos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/mep_front.sv
// ----------------------------------------------------------------------------
// Envelope front end
// Accepts samples, tracks the base window min/max and queues finished windows.
// ----------------------------------------------------------------------------
module mep_front import mep_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_beat_t            in_data,
  input  logic [WIN_BITS-1:0] cfg_window_len,
  input  q_stat_t             q_stat,
  output logic                push,
  output job_t                job
);

  logic [WIN_BITS-1:0]           fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_r, hi_nxt;
  logic [TOTAL_BITS-1:0]         total_r, total_inc;
  logic [WIN_BITS-1:0]           win_eff;
  logic [WIN_BITS-1:0]           fill_inc;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic                          accept;
  logic                          bin_done;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign smp      = in_data.sample;

  always_comb begin
    if (cfg_window_len < WIN_BITS'(WIN_MIN)) begin
      win_eff = WIN_BITS'(WIN_MIN);
    end else if (cfg_window_len > WIN_BITS'(WIN_MAX)) begin
      win_eff = WIN_BITS'(WIN_MAX);
    end else begin
      win_eff = cfg_window_len;
    end
  end

  always_comb begin
    fill_inc  = fill_r + 1'b1;
    total_inc = total_r + 1'b1;
    if (fill_r == '0) begin
      lo_nxt = smp;
      hi_nxt = smp;
    end else begin
      lo_nxt = (smp < lo_r) ? smp : lo_r;
      hi_nxt = (smp > hi_r) ? smp : hi_r;
    end
    bin_done = (fill_inc >= win_eff) || in_data.end_of_stream;
    fill_nxt = bin_done ? '0 : fill_inc;
  end

  assign push      = accept && bin_done;
  assign job.lo    = lo_nxt;
  assign job.hi    = hi_nxt;
  assign job.total = total_inc;
  assign job.eos   = in_data.end_of_stream;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
    end else if (accept) begin
      fill_r  <= fill_nxt;
      total_r <= in_data.end_of_stream ? '0 : total_inc;
    end
  end

  // Window extremes are only meaningful while the fill count is nonzero.
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

### rtl/mep_fifo.sv
// ----------------------------------------------------------------------------
// Window queue
// Short first-in first-out queue of finished base windows.
// ----------------------------------------------------------------------------
module mep_fifo import mep_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/mep_back.sv
// ----------------------------------------------------------------------------
// Pyramid cascade
// Walks a queued window up the levels, pairing bins; one level per cycle unless stalled.
// ----------------------------------------------------------------------------
module mep_back import mep_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LCNT_BITS-1:0] cfg_level_count,
  input  q_stat_t              q_stat,
  input  job_t                 head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LCW   = LCNT_BITS + 1;

  logic                          busy_r;
  logic [LVL_W-1:0]              lvl_r;
  logic [LVL_W-1:0]              top_r, top_c;
  logic                          have_r, have_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [TOTAL_BITS-1:0]         total_r;
  logic                          eos_r;
  logic [MAX_LEVELS-1:0]         pend_v_r;
  logic signed [SAMPLE_BITS-1:0] pend_lo_r [MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] pend_hi_r [MAX_LEVELS];
  logic                          out_valid_r;
  out_beat_t                     out_data_r;

  logic                          pv;
  logic signed [SAMPLE_BITS-1:0] plo, phi;
  logic at_top, step, emit, last_flag, finish;
  logic pend_set, pend_clr;

  always_comb begin
    if (cfg_level_count == '0) begin
      top_c = '0;
    end else if ({1'b0, cfg_level_count} > LCW'(MAX_LEVELS)) begin
      top_c = LVL_W'(MAX_LEVELS - 1);
    end else begin
      top_c = LVL_W'(cfg_level_count - 1'b1);
    end
  end

  assign pv  = pend_v_r[lvl_r];
  assign plo = pend_lo_r[lvl_r];
  assign phi = pend_hi_r[lvl_r];

  assign at_top    = (lvl_r == top_r);
  assign step      = busy_r && !(have_r && out_valid_r && !out_ready);
  assign emit      = step && have_r;
  // A bin is the last of its input when nothing can climb past this level.
  assign last_flag = at_top || (!pv && !eos_r);
  assign pop       = !busy_r && !q_stat.empty;

  always_comb begin
    have_nxt = have_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    pend_set = 1'b0;
    pend_clr = 1'b0;
    if (have_r) begin
      if (pv) begin
        lo_nxt   = (plo < lo_r) ? plo : lo_r;
        hi_nxt   = (phi > hi_r) ? phi : hi_r;
        pend_clr = 1'b1;
      end else if (!eos_r) begin
        pend_set = 1'b1;
        have_nxt = 1'b0;
      end
    end else if (eos_r && pv) begin
      have_nxt = 1'b1;
      lo_nxt   = plo;
      hi_nxt   = phi;
      pend_clr = 1'b1;
    end
    finish = at_top || (!have_nxt && !eos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (step && finish) begin
        busy_r <= 1'b0;
      end
      if (step && !at_top && pend_set) begin
        pend_v_r[lvl_r] <= 1'b1;
      end else if (step && !at_top && pend_clr) begin
        pend_v_r[lvl_r] <= 1'b0;
      end
      if (step && finish && eos_r) begin
        pend_v_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lvl_r   <= '0;
      top_r   <= top_c;
      have_r  <= 1'b1;
      lo_r    <= head_job.lo;
      hi_r    <= head_job.hi;
      total_r <= head_job.total;
      eos_r   <= head_job.eos;
    end else if (step && !at_top) begin
      lvl_r  <= lvl_r + 1'b1;
      have_r <= have_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
    if (step && !at_top && pend_set) begin
      pend_lo_r[lvl_r] <= lo_r;
      pend_hi_r[lvl_r] <= hi_r;
    end
    if (emit) begin
      out_data_r.level         <= LEVEL_BITS'(lvl_r);
      out_data_r.bin_min       <= lo_r;
      out_data_r.bin_max       <= hi_r;
      out_data_r.total_samples <= total_r;
      out_data_r.stream_done   <= eos_r && last_flag;
      out_data_r.last          <= last_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/minmax_envelope_pyramid.sv
// ----------------------------------------------------------------------------
// Min/max envelope pyramid
// Builds a multi-level min/max decimation pyramid over a mono sample stream.
// ----------------------------------------------------------------------------
// Usage: samples enter as beats on the in_ channel (valid/ready). Each beat
// carries one signed Q1.15 sample and an end-of-stream flag. A beat that
// fills the base window, or ends the stream, produces one bin at level 0 and
// then coarser bins as pairs complete; every bin leaves as one beat on the
// out_ channel, lowest level first, with last set on the final bin of the
// input beat and stream_done on the final bin of the stream.
// Throughput: the front end takes one sample per cycle. A finished window is
// placed in a four-entry queue; the cascade then walks it up the levels, as far
// as the top level set by level_count, and takes the next window from the queue
// only once it is done with the current one. The first bin of a window passes
// through the queue, the cascade load and the output register before it appears.
// The input stalls only when the queue is full, which happens when very short
// streams arrive back to back or while the receiver holds off the out_ channel.
// Reset clears the window, the running total, all pending pairs and the output
// register; window_len returns to 256 and level_count to 16. When the receiver
// stalls, the cascade holds its current level, the queue absorbs further windows,
// and the input keeps flowing until the queue fills. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata while idle, which the user, not the block, must ensure.
// ----------------------------------------------------------------------------
`include "minmax_envelope_pyramid_macros.svh"

module minmax_envelope_pyramid import mep_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_beat_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // Configuration registers; clamping to the legal range happens where used.
  logic [WIN_BITS-1:0]  window_len_r;
  logic [LCNT_BITS-1:0] level_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= WIN_BITS'(WIN_RESET);
      level_count_r <= LCNT_BITS'(LCNT_RESET);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW_LEN:  window_len_r  <= WIN_BITS'(cfg_wdata);
        REG_LEVEL_COUNT: level_count_r <= LCNT_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Front end: window tracking and queue push.
  logic    push, pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  mep_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .cfg_window_len (window_len_r),
    .q_stat         (q_stat),
    .push           (push),
    .job            (push_job)
  );

  // The queue decouples sample intake from the level cascade.
  mep_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Back end: one level per cycle while not stalled, output register toward the receiver.
  mep_back #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_level_count (level_count_r),
    .q_stat          (q_stat),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

  // Short names for the output checks below.
  logic                  done_beat;
  logic                  mid_fire;
  logic                  out_stall;
  logic [LEVEL_BITS-1:0] out_level;
  logic [LEVEL_BITS-1:0] level_up;

  assign done_beat = out_valid && out_data.stream_done;
  assign mid_fire  = out_valid && out_ready && !out_data.last;
  assign out_stall = out_valid && !out_ready;
  assign out_level = out_data.level;
  assign level_up  = out_data.level + 1'b1;

  // The final bin of a stream always closes its input beat.
  `MEP_ASSERT_SAME(a_done_is_last, done_beat, out_data.last, "stream_done without last")

  // Within one input beat, bins climb exactly one level per beat.
  `MEP_ASSERT_NEXT(a_level_climb, mid_fire, out_valid && out_level == $past(level_up), "level skipped")

  // A stalled bin keeps its payload until the receiver takes it.
  `MEP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "bin changed under stall")

endmodule
